FILE: hw/rtl/slp_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the slerp unit.
// Used by every module under hw/rtl except slp_delay; depends on nothing else.
package slp_pkg;

  localparam int SQ_STEPS     = 29;  // one result bit of the square root per stage
  localparam int CORDIC_STEPS = 30;  // one micro-rotation per stage
  localparam int DIV_STEPS    = 33;  // one quotient bit per stage

  localparam logic [15:0] NEAR_RESET = 16'd328;
  localparam logic [15:0] BLEND_ONE  = 16'd32768;

  // Side data that rides along the pipeline next to the arithmetic units.
  typedef struct packed {
    logic [3:0][15:0] a;     // start quaternion, Q1.14
    logic [3:0][16:0] b;     // target quaternion, sign extended, short-arc corrected
    logic [15:0]      t;     // clamped blend factor, Q1.15
    logic             flag;  // slerp allowed (before S4 unused), later linear select
  } side_t;

  // Arctangent of 2^-idx in Q30, truncated.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd843314856;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043836;
      5'd3:    v = 32'd133525158;
      5'd4:    v = 32'd67021686;
      5'd5:    v = 32'd33543515;
      5'd6:    v = 32'd16775850;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194282;
      5'd9:    v = 32'd2097149;
      default: v = (32'd1 << (5'd30 - idx)) - 32'd1;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/slp_delay.sv
// Pipelined delay line for side data and its valid bit.
// Depends on nothing; used by the slerp top level.
module slp_delay #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_r  [DEPTH];
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        data_r[k] <= data_r[k-1];
      end
    end
  end

  assign valid_o = valid_r[DEPTH-1];
  assign data_o  = data_r[DEPTH-1];

endmodule

FILE: hw/rtl/slp_isqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on slp_pkg for the stage count.
module slp_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [56:0] rad_i,
  output logic [28:0] root_o
);

  logic [56:0] v_r   [slp_pkg::SQ_STEPS];
  logic [57:0] res_r [slp_pkg::SQ_STEPS];

  genvar j;
  generate
    for (j = 0; j < slp_pkg::SQ_STEPS; j++) begin : g_stage
      localparam logic [57:0] BIT = 58'd1 << (2 * (slp_pkg::SQ_STEPS - 1 - j));
      logic [56:0] v_in;
      logic [57:0] res_in;
      logic [57:0] trial;

      if (j == 0) begin : g_first
        assign v_in   = rad_i;
        assign res_in = '0;
      end else begin : g_rest
        assign v_in   = v_r[j-1];
        assign res_in = res_r[j-1];
      end

      assign trial = res_in + BIT;

      always_ff @(posedge clk) begin
        if (en) begin
          if ({1'b0, v_in} >= trial) begin
            v_r[j]   <= v_in - trial[56:0];
            res_r[j] <= (res_in >> 1) + BIT;
          end else begin
            v_r[j]   <= v_in;
            res_r[j] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign root_o = res_r[slp_pkg::SQ_STEPS-1][28:0];

endmodule

FILE: hw/rtl/slp_cordic_vec.sv
// Pipelined CORDIC in vectoring mode: angle of (x, y) in Q30, clamped at zero.
// Depends on slp_pkg for the arctangent table and stage count.
module slp_cordic_vec (
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] x_i,
  input  logic [28:0] y_i,
  output logic [30:0] ang_o
);

  logic signed [31:0] x_r [slp_pkg::CORDIC_STEPS];
  logic signed [31:0] y_r [slp_pkg::CORDIC_STEPS];
  logic signed [32:0] z_r [slp_pkg::CORDIC_STEPS];

  genvar i;
  generate
    for (i = 0; i < slp_pkg::CORDIC_STEPS; i++) begin : g_stage
      localparam logic signed [32:0] ATAN = {1'b0, slp_pkg::atan_entry(5'(i))};
      logic signed [31:0] x_in, y_in, dx, dy;
      logic signed [32:0] z_in;

      if (i == 0) begin : g_first
        assign x_in = $signed({4'b0, x_i});
        assign y_in = $signed({3'b0, y_i});
        assign z_in = '0;
      end else begin : g_rest
        assign x_in = x_r[i-1];
        assign y_in = y_r[i-1];
        assign z_in = z_r[i-1];
      end

      assign dx = y_in >>> i;
      assign dy = x_in >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_in[31]) begin
            x_r[i] <= x_in + dx;
            y_r[i] <= y_in - dy;
            z_r[i] <= z_in + ATAN;
          end else begin
            x_r[i] <= x_in - dx;
            y_r[i] <= y_in + dy;
            z_r[i] <= z_in - ATAN;
          end
        end
      end
    end
  endgenerate

  assign ang_o = z_r[slp_pkg::CORDIC_STEPS-1][32] ? '0
               : z_r[slp_pkg::CORDIC_STEPS-1][30:0];

endmodule

FILE: hw/rtl/slp_cordic_rot.sv
// Pipelined CORDIC in rotation mode: scaled sine of a Q30 angle, clamped at zero.
// Depends on slp_pkg for the arctangent table and stage count.
module slp_cordic_rot (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] ang_i,
  output logic [31:0] sin_o
);

  logic signed [32:0] x_r [slp_pkg::CORDIC_STEPS];
  logic signed [32:0] y_r [slp_pkg::CORDIC_STEPS];
  logic signed [32:0] z_r [slp_pkg::CORDIC_STEPS];

  genvar i;
  generate
    for (i = 0; i < slp_pkg::CORDIC_STEPS; i++) begin : g_stage
      localparam logic signed [32:0] ATAN = {1'b0, slp_pkg::atan_entry(5'(i))};
      logic signed [32:0] x_in, y_in, z_in, dx, dy;

      if (i == 0) begin : g_first
        assign x_in = 33'sd1073741824;
        assign y_in = '0;
        assign z_in = $signed({2'b0, ang_i});
      end else begin : g_rest
        assign x_in = x_r[i-1];
        assign y_in = y_r[i-1];
        assign z_in = z_r[i-1];
      end

      assign dx = y_in >>> i;
      assign dy = x_in >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_in[32]) begin
            x_r[i] <= x_in - dx;
            y_r[i] <= y_in + dy;
            z_r[i] <= z_in - ATAN;
          end else begin
            x_r[i] <= x_in + dx;
            y_r[i] <= y_in - dy;
            z_r[i] <= z_in + ATAN;
          end
        end
      end
    end
  endgenerate

  assign sin_o = y_r[slp_pkg::CORDIC_STEPS-1][32] ? '0
               : y_r[slp_pkg::CORDIC_STEPS-1][31:0];

endmodule

FILE: hw/rtl/slp_div.sv
// Pipelined restoring divider: floor((num << 30) / den), one quotient bit per stage.
// Depends on slp_pkg for the stage count.
module slp_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [32:0] quo_o
);

  logic [33:0] rem_r [slp_pkg::DIV_STEPS];
  logic [32:0] quo_r [slp_pkg::DIV_STEPS];
  logic [31:0] num_r [slp_pkg::DIV_STEPS];
  logic [31:0] den_r [slp_pkg::DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < slp_pkg::DIV_STEPS; k++) begin : g_stage
      localparam int P = slp_pkg::DIV_STEPS - 1 - k;  // quotient bit made here
      logic [33:0] rem_in, shifted;
      logic [32:0] quo_in;
      logic [31:0] num_in, den_in;
      logic        nbit;

      if (k == 0) begin : g_first
        // The dividend bits above the quotient window seed the remainder.
        assign rem_in = {5'b0, num_i[31:3]};
        assign quo_in = '0;
        assign num_in = num_i;
        assign den_in = den_i;
      end else begin : g_rest
        assign rem_in = rem_r[k-1];
        assign quo_in = quo_r[k-1];
        assign num_in = num_r[k-1];
        assign den_in = den_r[k-1];
      end

      // The dividend is num shifted up by 30, so its low 30 bits are zero.
      if (P >= 30) begin : g_nbit
        assign nbit = num_in[P-30];
      end else begin : g_zbit
        assign nbit = 1'b0;
      end

      assign shifted = {rem_in[32:0], nbit};

      always_ff @(posedge clk) begin
        if (en) begin
          num_r[k] <= num_in;
          den_r[k] <= den_in;
          if (shifted >= {2'b0, den_in}) begin
            rem_r[k] <= shifted - {2'b0, den_in};
            quo_r[k] <= quo_in | (33'd1 << P);
          end else begin
            rem_r[k] <= shifted;
            quo_r[k] <= quo_in;
          end
        end
      end
    end
  endgenerate

  assign quo_o = quo_r[slp_pkg::DIV_STEPS-1];

endmodule

FILE: hw/rtl/quaternion_slerp_unit.sv
// Top level of the quaternion slerp unit: dot product, arc test, square root,
// CORDIC angle and sines, weight division and output blend. Depends on slp_pkg,
// slp_delay, slp_isqrt, slp_cordic_vec, slp_cordic_rot and slp_div.
//
//  Channel   Direction  Content
//  in_*      in         start and target quaternions plus blend factor, one beat each
//  out_*     out        interpolated quaternion, one beat per input beat
//  cfg_*     in         near_threshold register write
//
// The unit accepts one beat in every clock cycle while in_tready is high. Each
// result runs through the square root, the two CORDIC chains and the divider,
// each one step per stage, and then through the blend stages.
// Reset (synchronous, active low) empties the pipeline and loads near_threshold
// with 328. When the result register is full and out_tready is low, the whole
// pipeline holds and in_tready drops, so nothing is lost or repeated.
module quaternion_slerp_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, blend (16 bits each)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, out_w (16 bits each)
  output logic [63:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  // The pipeline moves as one piece whenever the result register can take a beat.
  logic out_tvalid_r;
  logic adv;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  logic [15:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= slp_pkg::NEAR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Stage 1: clamp the blend factor and form the four component products.
  slp_pkg::side_t     in_side;
  logic [15:0]        blend;
  logic signed [31:0] prod1_r [4];
  slp_pkg::side_t     s1_r;
  logic               v1_r;

  assign blend = in_tdata[143:128];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_side.a[i] = in_tdata[16*i +: 16];
      in_side.b[i] = {in_tdata[64+16*i+15], in_tdata[64+16*i +: 16]};
    end
    in_side.t    = (blend > slp_pkg::BLEND_ONE) ? slp_pkg::BLEND_ONE : blend;
    in_side.flag = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_side;
      for (int i = 0; i < 4; i++) begin
        prod1_r[i] <= $signed(in_side.a[i]) * $signed(in_side.b[i][15:0]);
      end
    end
  end

  // Stage 2: the dot product, exact in Q5.28.
  logic signed [33:0] dot2_r;
  slp_pkg::side_t     s2_r;
  logic               v2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r   <= s1_r;
      dot2_r <= 34'(prod1_r[0]) + 34'(prod1_r[1]) + 34'(prod1_r[2]) + 34'(prod1_r[3]);
    end
  end

  // Stage 3: a negative cosine flips the target so the blend takes the short arc.
  logic [32:0]    c3_r;
  slp_pkg::side_t s3_nxt;
  slp_pkg::side_t s3_r;
  logic           v3_r;

  always_comb begin
    s3_nxt = s2_r;
    for (int i = 0; i < 4; i++) begin
      s3_nxt.b[i] = dot2_r[33] ? 17'(-$signed(s2_r.b[i])) : s2_r.b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
      c3_r <= dot2_r[33] ? 33'(-dot2_r) : dot2_r[32:0];
    end
  end

  // Stage 4: arc test against the threshold and the square of the cosine.
  // Whenever the arc test passes the cosine is below 2^28, so 28 bits suffice.
  logic signed [34:0] gap;
  logic [55:0]        csq4_r;
  logic [27:0]        c4_r;
  slp_pkg::side_t     s4_nxt;
  slp_pkg::side_t     s4_r;
  logic               v4_r;

  assign gap = 35'sd268435456 - $signed({2'b0, c3_r});

  always_comb begin
    s4_nxt      = s3_r;
    s4_nxt.flag = gap > $signed({6'b0, thr_r, 13'b0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r   <= s4_nxt;
      c4_r   <= c3_r[27:0];
      csq4_r <= c3_r[27:0] * c3_r[27:0];
    end
  end

  // Sine of the half-turn angle: floor(sqrt(1 - c^2)) in Q28.
  logic [56:0] rad;
  logic [28:0] root;
  assign rad = (57'd1 << 56) - {1'b0, csq4_r};

  slp_isqrt u_isqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (rad),
    .root_o (root)
  );

  logic           v33;
  slp_pkg::side_t s33;
  logic [27:0]    c33;

  slp_delay #(
    .DEPTH (slp_pkg::SQ_STEPS),
    .WIDTH ($bits(slp_pkg::side_t) + 28)
  ) u_dly_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v4_r),
    .data_i  ({s4_r, c4_r}),
    .valid_o (v33),
    .data_o  ({s33, c33})
  );

  // Arc angle w = atan2(s, c).
  logic [30:0] ang;

  slp_cordic_vec u_vec (
    .clk   (clk),
    .en    (adv),
    .x_i   (c33),
    .y_i   (root),
    .ang_o (ang)
  );

  logic           v63;
  slp_pkg::side_t s63;

  slp_delay #(
    .DEPTH (slp_pkg::CORDIC_STEPS),
    .WIDTH ($bits(slp_pkg::side_t))
  ) u_dly_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v33),
    .data_i  (s33),
    .valid_o (v63),
    .data_o  (s63)
  );

  // Stage 64: split the angle by the blend factor, rounding down.
  logic [15:0]    tc63;
  logic [46:0]    ang0_full, ang1_full;
  logic [30:0]    ang0_r, ang1_r, angw_r;
  slp_pkg::side_t s64_r;
  logic           v64_r;

  assign tc63      = slp_pkg::BLEND_ONE - s63.t;
  assign ang0_full = ang * tc63;
  assign ang1_full = ang * s63.t;

  always_ff @(posedge clk) begin
    if (adv) begin
      s64_r  <= s63;
      angw_r <= ang;
      ang0_r <= ang0_full[45:15];
      ang1_r <= ang1_full[45:15];
    end
  end

  // Three sines side by side; the CORDIC gain cancels in the ratios.
  logic [31:0] sin_w, sin_0, sin_1;

  slp_cordic_rot u_rot_w (.clk(clk), .en(adv), .ang_i(angw_r), .sin_o(sin_w));
  slp_cordic_rot u_rot_0 (.clk(clk), .en(adv), .ang_i(ang0_r), .sin_o(sin_0));
  slp_cordic_rot u_rot_1 (.clk(clk), .en(adv), .ang_i(ang1_r), .sin_o(sin_1));

  logic           v94;
  slp_pkg::side_t s94, s94_lin;

  slp_delay #(
    .DEPTH (slp_pkg::CORDIC_STEPS),
    .WIDTH ($bits(slp_pkg::side_t))
  ) u_dly_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v64_r),
    .data_i  (s64_r),
    .valid_o (v94),
    .data_o  (s94)
  );

  // From here on the flag means "use the linear weights": either the arc is
  // too short or the sine of the whole arc came out as zero.
  always_comb begin
    s94_lin      = s94;
    s94_lin.flag = !s94.flag || (sin_w == '0);
  end

  logic [32:0] quo0, quo1;

  slp_div u_div_0 (.clk(clk), .en(adv), .num_i(sin_0), .den_i(sin_w), .quo_o(quo0));
  slp_div u_div_1 (.clk(clk), .en(adv), .num_i(sin_1), .den_i(sin_w), .quo_o(quo1));

  logic           v127;
  slp_pkg::side_t s127;

  slp_delay #(
    .DEPTH (slp_pkg::DIV_STEPS),
    .WIDTH ($bits(slp_pkg::side_t))
  ) u_dly_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (v94),
    .data_i  (s94_lin),
    .valid_o (v127),
    .data_o  (s127)
  );

  // Stage 128: pick the weights and multiply each component.
  logic [15:0]        tc127;
  logic [32:0]        wt0, wt1;
  logic signed [49:0] p0_r [4];
  logic signed [50:0] p1_r [4];
  logic               v128_r;

  assign tc127 = slp_pkg::BLEND_ONE - s127.t;
  assign wt0   = s127.flag ? {2'b0, tc127, 15'b0} : quo0;
  assign wt1   = s127.flag ? {2'b0, s127.t, 15'b0} : quo1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p0_r[i] <= $signed({1'b0, wt0}) * $signed(s127.a[i]);
        p1_r[i] <= $signed({1'b0, wt1}) * $signed(s127.b[i]);
      end
    end
  end

  // Result register: round to nearest (ties up), back to Q1.14, saturate.
  logic signed [51:0] acc  [4];
  logic signed [21:0] rnd  [4];
  logic [63:0]        out_nxt;
  logic [63:0]        out_tdata_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = 52'(p0_r[i]) + 52'(p1_r[i]) + 52'sd536870912;
      rnd[i] = 22'(acc[i] >>> 30);
      if (rnd[i] > 22'sd32767) begin
        out_nxt[16*i +: 16] = 16'h7fff;
      end else if (rnd[i] < -22'sd32768) begin
        out_nxt[16*i +: 16] = 16'h8000;
      end else begin
        out_nxt[16*i +: 16] = rnd[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_nxt;
    end
  end

  // Valid bits of the register stages outside the delay lines.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v64_r        <= 1'b0;
      v128_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v64_r        <= v63;
      v128_r       <= v127;
      out_tvalid_r <= v128_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // A result only appears when the last multiply stage held a beat.
  a_out_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(v128_r))
    else $error("result appeared without a beat in the multiply stage");

  // A stall freezes the middle of the pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v64_r) && $stable(angw_r))
    else $error("pipeline moved during a stall");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid_r)
    else $error("result valid right after reset");
`endif

endmodule

FILE: bench/quaternion_slerp_unit_checker.sv
// Checker for the quaternion slerp unit: watches the input, result and register
// write ports, predicts each result in fixed point and compares. Depends on nothing.
module quaternion_slerp_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_STEPS = 30;

  logic [15:0] threshold_q;
  logic [63:0] expected_quats[$];

  assign pending = expected_quats.size();

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint arctan_q30(int i);
    case (i)
      0: return 843314856;
      1: return 497837829;
      2: return 263043836;
      3: return 133525158;
      4: return 67021686;
      5: return 33543515;
      6: return 16775850;
      7: return 8388437;
      8: return 4194282;
      9: return 2097149;
      default: return (64'sd1 <<< (30 - i)) - 1;
    endcase
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q30, clamped at zero.
  function automatic longint arc_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q30(i);
      end else begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  // Rotation CORDIC from (2^30, 0); the gain cancels in the weight ratios.
  function automatic longint scaled_sine(longint z);
    longint x, y, dx, dy;
    x = 64'sd1 <<< 30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    return (y < 0) ? 0 : y;
  endfunction

  function automatic logic [63:0] slerp_result(logic [143:0] beat, logic [15:0] thr);
    longint a[4], b[4], dot, w0, w1, s, ang, sw, acc, r;
    longint unsigned t, cu;
    logic [63:0] res;
    t = beat[143:128];
    if (t > 32768) t = 32768;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(beat[16*i +: 16]));
      b[i] = longint'($signed(beat[64 + 16*i +: 16]));
      dot += a[i] * b[i];
    end
    if (dot < 0) begin
      dot = -dot;
      for (int i = 0; i < 4; i++) b[i] = -b[i];
    end
    w0 = longint'(32768 - t) <<< 15;
    w1 = longint'(t) <<< 15;
    if ((64'sd1 <<< 28) - dot > (longint'(thr) <<< 13)) begin
      cu = longint'(dot);
      s = int_sqrt((64'd1 << 56) - cu * cu);
      ang = arc_angle(dot, s);
      sw = scaled_sine(ang);
      if (sw > 0) begin
        w0 = longint'((unsigned'(scaled_sine((ang * longint'(32768 - t)) >>> 15))
             << 30) / unsigned'(sw));
        w1 = longint'((unsigned'(scaled_sine((ang * longint'(t)) >>> 15))
             << 30) / unsigned'(sw));
      end
    end
    for (int i = 0; i < 4; i++) begin
      acc = w0 * a[i] + w1 * b[i] + (64'sd1 <<< 29);
      r = acc >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      res[16*i +: 16] = r[15:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      threshold_q <= 16'd328;
      expected_quats.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_quats.push_back(slerp_result(in_tdata, threshold_q));
      if (cfg_wr_en) threshold_q <= cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (expected_quats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_quats.pop_front();
          for (int i = 0; i < 4; i++)
            if (out_tdata[16*i +: 16] !== want[16*i +: 16])
              report_mismatch($sformatf("component %0d got %h want %h", i,
                                        out_tdata[16*i +: 16], want[16*i +: 16]));
        end
      end
    end
  end
endmodule

FILE: bench/quaternion_slerp_unit_tb.sv
// Stimulus top for the quaternion slerp unit: drives input beats and register
// writes, stalls the result side, and gives the verdict. Depends on the checker and the unit.
module quaternion_slerp_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 129;
  localparam int MAX_CYCLE = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;
  int           errors;
  int           pending;
  int           cycle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_slerp_unit dut (.*);
  quaternion_slerp_unit_checker chk (.*);

  // The run is cut off if the pipeline ever wedges.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The result side stalls in phases: some stretches always ready, others random.
  always @(posedge clk) begin
    if ((cycle / 700) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) < 60);
  end

  // Random component, biased toward full scale and small magnitudes now and then.
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // A unit-ish quaternion so the arc test sees realistic cosines.
  function automatic logic [63:0] near_unit();
    logic [63:0] q;
    q = '0;
    q[16*$urandom_range(0, 3) +: 16] = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
    for (int i = 0; i < 4; i++)
      q[16*i +: 16] = q[16*i +: 16] + 16'($signed($urandom_range(0, 12000)) - 6000);
    return q;
  endfunction

  function automatic logic [15:0] rand_blend();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Sends one beat; valid stays high so the next beat can follow at once.
  task automatic send_beat(logic [143:0] beat);
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drops valid for an idle gap of the given length.
  task automatic idle(int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [63:0] p, q;
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        idle($urandom_range(0, 6));
        burst = $urandom_range(1, 40);
      end
      burst--;
      if ($urandom_range(0, 9) < 7) begin
        p = near_unit();
        q = ($urandom_range(0, 3) == 0) ? p : near_unit();
        if ($urandom_range(0, 4) == 0) q = -q;
      end else begin
        p = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      end
      send_beat({rand_blend(), q, p});
    end
  endtask

  initial begin
    logic [63:0] id, qa;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset threshold: identical and opposite
    // quaternions, a right angle, full-scale extremes, blend above one, zeros.
    id = {16'sd16384, 48'd0};
    qa = {16'd0, 16'd0, 16'd0, 16'sd16384};
    send_beat({16'd0, id, id});
    send_beat({16'd16384, id, id});
    send_beat({16'd16384, -id, id});
    send_beat({16'd0, qa, id});
    send_beat({16'd16384, qa, id});
    send_beat({16'd32768, qa, id});
    send_beat({16'hffff, qa, id});
    send_beat({16'd40000, -qa, id});
    send_beat({16'd16384, {4{16'h7fff}}, {4{16'h8000}}});
    send_beat({16'd8192, {4{16'h8000}}, {4{16'h8000}}});
    send_beat({16'd8192, {4{16'h7fff}}, {4{16'h7fff}}});
    send_beat({16'd12000, 64'd0, 64'd0});
    send_beat({16'd1, {16'sd16380, 16'sd300, 48'd0}, id});
    send_beat({16'd32767, {16'sd11585, 16'sd11585, 32'd0}, id});
    send_beat({16'hffff, {4{16'hffff}}, {4{16'hffff}}});
    drain();

    // Sweep the threshold through its extremes and a few settings in between.
    write_threshold(16'd0);
    random_phase(250);
    drain();
    write_threshold(16'hffff);
    random_phase(200);
    drain();
    write_threshold(16'd32768);
    random_phase(200);
    drain();
    write_threshold(16'd5000);
    random_phase(300);
    // Hold the sender until everything in flight has come out.
    drain();
    write_threshold(16'd328);
    random_phase(550);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
